@@ rtl/core/e2d_pkg.sv @@
// Package for the 2-D Euler stencil step: fixed-point types, arithmetic helpers,
// register-file map and the micro-program run by the back end.
// No dependencies; the top, front end, queue and back end import it.
package e2d_pkg;

    typedef logic signed [63:0] fx_t;

    typedef struct packed {
        fx_t  value;
        logic sat;
    } fx_res_t;

    localparam int MAX_ROWS    = 256;
    localparam int MAX_COLS    = 65533;
    localparam int COL_SPAN    = MAX_ROWS + 2;
    localparam int STORE_DEPTH = 2 * COL_SPAN;
    localparam int STORE_AW    = $clog2(STORE_DEPTH);
    localparam int CELL_W      = 256;

    localparam fx_t FX_MIN = 64'sh8000_0000_0000_0000;
    localparam fx_t FX_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam fx_t GAMMA_Q    = 64'sd23488102;
    localparam fx_t GAMMA_M1_Q = 64'sd6710886;

    localparam logic [1:0] CFG_GRID_COLS  = 2'd0;
    localparam logic [1:0] CFG_GRID_ROWS  = 2'd1;
    localparam logic [1:0] CFG_INV_TWO_DX = 2'd2;
    localparam logic [1:0] CFG_TIME_STEP  = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_SAT      = 2'd1;
    localparam logic [1:0] ST_ZERO_DIV = 2'd2;

    typedef struct packed {
        fx_t [19:0] window;
        logic       zero_div;
        logic       last;
    } q_entry_t;

    typedef struct packed {
        logic full;
        logic not_empty;
    } q_stat_t;

    typedef enum logic [2:0] {
        F_IDLE,
        F_READ_WC,
        F_READ_NS,
        F_WRITE,
        F_PUSH
    } front_state_t;

    typedef enum logic [3:0] {
        B_IDLE,
        B_LOAD,
        B_FETCH,
        B_EXEC,
        B_MUL,
        B_MUL_FIN,
        B_DIV,
        B_DIV_FIN,
        B_WB,
        B_DONE
    } back_state_t;

    typedef enum logic [2:0] {
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV,
        OP_HALF
    } op_t;

    typedef logic [5:0] rf_addr_t;

    localparam int RF_DEPTH = 47;
    localparam int LOAD_LEN = 24;
    localparam int PROG_LEN = 85;

    // window cells: centre, north, south, east, west; fields r, m, n, p
    localparam rf_addr_t RF_R0 = 6'd0,  RF_M0 = 6'd1,  RF_N0 = 6'd2,  RF_P0 = 6'd3;
    localparam rf_addr_t RF_RN = 6'd4,  RF_MN = 6'd5,  RF_NN = 6'd6,  RF_PN = 6'd7;
    localparam rf_addr_t RF_RS = 6'd8,  RF_MS = 6'd9,  RF_NS = 6'd10, RF_PS = 6'd11;
    localparam rf_addr_t RF_RE = 6'd12, RF_ME = 6'd13, RF_NE = 6'd14, RF_PE = 6'd15;
    localparam rf_addr_t RF_RW = 6'd16, RF_MW = 6'd17, RF_NW = 6'd18, RF_PW = 6'd19;
    localparam rf_addr_t RF_K  = 6'd20, RF_DT = 6'd21, RF_G  = 6'd22, RF_G1 = 6'd23;
    localparam rf_addr_t RF_U0 = 6'd24, RF_UN = 6'd25, RF_US = 6'd26, RF_UE = 6'd27;
    localparam rf_addr_t RF_UW = 6'd28;
    localparam rf_addr_t RF_V0 = 6'd29, RF_VN = 6'd30, RF_VS = 6'd31, RF_VE = 6'd32;
    localparam rf_addr_t RF_VW = 6'd33;
    localparam rf_addr_t RF_MASS = 6'd34, RF_RU0 = 6'd35, RF_RV0 = 6'd36;
    localparam rf_addr_t RF_MOMX = 6'd37, RF_MOMY = 6'd38;
    localparam rf_addr_t RF_T0 = 6'd39, RF_T1 = 6'd40, RF_T2 = 6'd41, RF_T3 = 6'd42;
    localparam rf_addr_t RF_RES0 = 6'd43, RF_RES1 = 6'd44, RF_RES2 = 6'd45;
    localparam rf_addr_t RF_RES3 = 6'd46;

    typedef struct packed {
        op_t      op;
        rf_addr_t dst;
        rf_addr_t src_a;
        rf_addr_t src_b;
    } instr_t;

    function automatic logic [63:0] fx_mag(input fx_t a);
        return a[63] ? (~a + 64'd1) : a;
    endfunction

    function automatic fx_res_t fx_sat(input logic hi, input logic [63:0] mag,
                                       input logic neg);
        fx_res_t r;
        if (neg) begin
            if (hi || (mag > 64'h8000_0000_0000_0000)) begin
                r.value = FX_MIN;
                r.sat   = 1'b1;
            end
            else begin
                r.value = ~mag + 64'd1;
                r.sat   = 1'b0;
            end
        end
        else begin
            if (hi || mag[63]) begin
                r.value = FX_MAX;
                r.sat   = 1'b1;
            end
            else begin
                r.value = mag;
                r.sat   = 1'b0;
            end
        end
        return r;
    endfunction

    function automatic fx_res_t fx_add(input fx_t a, input fx_t b);
        fx_res_t r;
        fx_t     s;
        s = a + b;
        if ((a[63] == b[63]) && (s[63] != a[63])) begin
            r.value = a[63] ? FX_MIN : FX_MAX;
            r.sat   = 1'b1;
        end
        else begin
            r.value = s;
            r.sat   = 1'b0;
        end
        return r;
    endfunction

    function automatic fx_res_t fx_sub(input fx_t a, input fx_t b);
        fx_res_t r;
        fx_t     s;
        s = a - b;
        if ((a[63] != b[63]) && (s[63] != a[63])) begin
            r.value = a[63] ? FX_MIN : FX_MAX;
            r.sat   = 1'b1;
        end
        else begin
            r.value = s;
            r.sat   = 1'b0;
        end
        return r;
    endfunction

    function automatic fx_res_t fx_half(input fx_t a);
        fx_res_t r;
        fx_t     s;
        s = a + {63'd0, a[63]};
        r.value = s >>> 1;
        r.sat   = 1'b0;
        return r;
    endfunction

    function automatic instr_t ins(input op_t op, input rf_addr_t d, input rf_addr_t a,
                                   input rf_addr_t b);
        instr_t i;
        i.op    = op;
        i.dst   = d;
        i.src_a = a;
        i.src_b = b;
        return i;
    endfunction

    function automatic instr_t prog_instr(input logic [6:0] pc);
        instr_t i;
        case (pc)
            7'd0:  i = ins(OP_DIV, RF_U0, RF_M0, RF_R0);
            7'd1:  i = ins(OP_DIV, RF_V0, RF_N0, RF_R0);
            7'd2:  i = ins(OP_DIV, RF_UN, RF_MN, RF_RN);
            7'd3:  i = ins(OP_DIV, RF_VN, RF_NN, RF_RN);
            7'd4:  i = ins(OP_DIV, RF_US, RF_MS, RF_RS);
            7'd5:  i = ins(OP_DIV, RF_VS, RF_NS, RF_RS);
            7'd6:  i = ins(OP_DIV, RF_UE, RF_ME, RF_RE);
            7'd7:  i = ins(OP_DIV, RF_VE, RF_NE, RF_RE);
            7'd8:  i = ins(OP_DIV, RF_UW, RF_MW, RF_RW);
            7'd9:  i = ins(OP_DIV, RF_VW, RF_NW, RF_RW);
            // mass flux
            7'd10: i = ins(OP_MUL, RF_T0, RF_RE, RF_ME);
            7'd11: i = ins(OP_MUL, RF_T1, RF_RW, RF_MW);
            7'd12: i = ins(OP_SUB, RF_T0, RF_T0, RF_T1);
            7'd13: i = ins(OP_MUL, RF_T1, RF_RN, RF_NN);
            7'd14: i = ins(OP_MUL, RF_T2, RF_RS, RF_NS);
            7'd15: i = ins(OP_SUB, RF_T1, RF_T1, RF_T2);
            7'd16: i = ins(OP_ADD, RF_T0, RF_T0, RF_T1);
            7'd17: i = ins(OP_MUL, RF_MASS, RF_T0, RF_K);
            7'd18: i = ins(OP_MUL, RF_RU0, RF_R0, RF_M0);
            7'd19: i = ins(OP_MUL, RF_RV0, RF_R0, RF_N0);
            // x momentum
            7'd20: i = ins(OP_MUL, RF_T0, RF_ME, RF_ME);
            7'd21: i = ins(OP_MUL, RF_T1, RF_MW, RF_MW);
            7'd22: i = ins(OP_SUB, RF_T0, RF_T0, RF_T1);
            7'd23: i = ins(OP_SUB, RF_T1, RF_UE, RF_UW);
            7'd24: i = ins(OP_MUL, RF_T1, RF_RU0, RF_T1);
            7'd25: i = ins(OP_ADD, RF_T0, RF_T0, RF_T1);
            7'd26: i = ins(OP_MUL, RF_T1, RF_MN, RF_NN);
            7'd27: i = ins(OP_MUL, RF_T2, RF_MS, RF_NS);
            7'd28: i = ins(OP_SUB, RF_T1, RF_T1, RF_T2);
            7'd29: i = ins(OP_ADD, RF_T0, RF_T0, RF_T1);
            7'd30: i = ins(OP_SUB, RF_T1, RF_UN, RF_US);
            7'd31: i = ins(OP_MUL, RF_T1, RF_RV0, RF_T1);
            7'd32: i = ins(OP_ADD, RF_T0, RF_T0, RF_T1);
            7'd33: i = ins(OP_MUL, RF_T0, RF_T0, RF_K);
            7'd34: i = ins(OP_HALF, RF_T0, RF_T0, RF_T0);
            7'd35: i = ins(OP_SUB, RF_T1, RF_PE, RF_PW);
            7'd36: i = ins(OP_MUL, RF_T1, RF_T1, RF_K);
            7'd37: i = ins(OP_ADD, RF_MOMX, RF_T0, RF_T1);
            // y momentum
            7'd38: i = ins(OP_MUL, RF_T0, RF_ME, RF_NE);
            7'd39: i = ins(OP_MUL, RF_T1, RF_MW, RF_NW);
            7'd40: i = ins(OP_SUB, RF_T0, RF_T0, RF_T1);
            7'd41: i = ins(OP_SUB, RF_T1, RF_VE, RF_VW);
            7'd42: i = ins(OP_MUL, RF_T1, RF_RU0, RF_T1);
            7'd43: i = ins(OP_ADD, RF_T0, RF_T0, RF_T1);
            7'd44: i = ins(OP_MUL, RF_T1, RF_NN, RF_NN);
            7'd45: i = ins(OP_MUL, RF_T2, RF_NS, RF_NS);
            7'd46: i = ins(OP_SUB, RF_T1, RF_T1, RF_T2);
            7'd47: i = ins(OP_ADD, RF_T0, RF_T0, RF_T1);
            7'd48: i = ins(OP_SUB, RF_T1, RF_VN, RF_VS);
            7'd49: i = ins(OP_MUL, RF_T1, RF_RV0, RF_T1);
            7'd50: i = ins(OP_ADD, RF_T0, RF_T0, RF_T1);
            7'd51: i = ins(OP_MUL, RF_T0, RF_T0, RF_K);
            7'd52: i = ins(OP_HALF, RF_T0, RF_T0, RF_T0);
            7'd53: i = ins(OP_SUB, RF_T1, RF_PN, RF_PS);
            7'd54: i = ins(OP_MUL, RF_T1, RF_T1, RF_K);
            7'd55: i = ins(OP_ADD, RF_MOMY, RF_T0, RF_T1);
            // energy
            7'd56: i = ins(OP_MUL, RF_T0, RF_PE, RF_UE);
            7'd57: i = ins(OP_MUL, RF_T1, RF_PW, RF_UW);
            7'd58: i = ins(OP_SUB, RF_T0, RF_T0, RF_T1);
            7'd59: i = ins(OP_MUL, RF_T1, RF_PN, RF_VN);
            7'd60: i = ins(OP_MUL, RF_T2, RF_PS, RF_VS);
            7'd61: i = ins(OP_SUB, RF_T1, RF_T1, RF_T2);
            7'd62: i = ins(OP_ADD, RF_T0, RF_T0, RF_T1);
            7'd63: i = ins(OP_SUB, RF_T1, RF_PE, RF_PW);
            7'd64: i = ins(OP_MUL, RF_T1, RF_U0, RF_T1);
            7'd65: i = ins(OP_SUB, RF_T2, RF_PN, RF_PS);
            7'd66: i = ins(OP_MUL, RF_T2, RF_V0, RF_T2);
            7'd67: i = ins(OP_ADD, RF_T1, RF_T1, RF_T2);
            7'd68: i = ins(OP_MUL, RF_T0, RF_T0, RF_K);
            7'd69: i = ins(OP_MUL, RF_T0, RF_T0, RF_G);
            7'd70: i = ins(OP_MUL, RF_T1, RF_T1, RF_K);
            7'd71: i = ins(OP_MUL, RF_T1, RF_T1, RF_G1);
            7'd72: i = ins(OP_ADD, RF_T3, RF_T0, RF_T1);
            // update
            7'd73: i = ins(OP_MUL, RF_T0, RF_DT, RF_T3);
            7'd74: i = ins(OP_SUB, RF_RES3, RF_P0, RF_T0);
            7'd75: i = ins(OP_HALF, RF_T0, RF_MASS, RF_MASS);
            7'd76: i = ins(OP_DIV, RF_T0, RF_T0, RF_R0);
            7'd77: i = ins(OP_MUL, RF_T0, RF_DT, RF_T0);
            7'd78: i = ins(OP_SUB, RF_RES0, RF_R0, RF_T0);
            7'd79: i = ins(OP_DIV, RF_T0, RF_MOMX, RF_R0);
            7'd80: i = ins(OP_MUL, RF_T0, RF_DT, RF_T0);
            7'd81: i = ins(OP_SUB, RF_RES1, RF_M0, RF_T0);
            7'd82: i = ins(OP_DIV, RF_T0, RF_MOMY, RF_R0);
            7'd83: i = ins(OP_MUL, RF_T0, RF_DT, RF_T0);
            7'd84: i = ins(OP_SUB, RF_RES2, RF_N0, RF_T0);
            default: i = ins(OP_ADD, RF_T0, RF_T0, RF_T0);
        endcase
        return i;
    endfunction

endpackage

@@ rtl/core/e2d_if.sv @@
// Valid/ready channel interfaces for grid cells in and updated cells out.
// No dependencies.
interface e2d_in_if;
    logic               valid;
    logic               ready;
    logic signed [63:0] root_density;
    logic signed [63:0] scaled_momentum_x;
    logic signed [63:0] scaled_momentum_y;
    logic signed [63:0] pressure_in;

    modport source (output valid, root_density, scaled_momentum_x, scaled_momentum_y,
                    pressure_in, input ready);
    modport sink (input valid, root_density, scaled_momentum_x, scaled_momentum_y,
                  pressure_in, output ready);
endinterface

interface e2d_out_if;
    logic               valid;
    logic               ready;
    logic signed [63:0] new_root_density;
    logic signed [63:0] new_momentum_x;
    logic signed [63:0] new_momentum_y;
    logic signed [63:0] new_pressure;
    logic [1:0]         status;
    logic               last_of_frame;

    modport source (output valid, new_root_density, new_momentum_x, new_momentum_y,
                    new_pressure, status, last_of_frame, input ready);
    modport sink (input valid, new_root_density, new_momentum_x, new_momentum_y,
                  new_pressure, status, last_of_frame, output ready);
endinterface

@@ rtl/core/euler2d_stencil_forward_step_top.sv @@
// Top level of the 2-D Euler forward step: configuration registers, front end,
// window queue and back end. Uses e2d_pkg, e2d_if, e2d_front, e2d_queue, e2d_back.
//
// channel   dir  handshake      payload
// cells     in   valid/ready    root_density, scaled_momentum_x/y, pressure_in
// results   out  valid/ready    new_* (4 x 64), status, last_of_frame
// cfg       in   cfg_write      cfg_index, cfg_data
//
// A ghost or first-column cell passes the read and write states of the front end
// and gives no item; an interior cell then waits in the push state for a free queue slot.
// In the back end an interior cell runs the program: thirteen quotients on the
// shared bit-serial divider, 37 products on the four-pass multiplier, 35 add-type
// steps, a load of 24 operands and a handoff.
// A cell with a zero sqrt-density anywhere in its window skips the program.
// Two windows queue between front and back; results stall the back end, and
// the front end once the queue is full.
module euler2d_stencil_forward_step_top (
    input  logic        clk,
    input  logic        rst_n,
    e2d_in_if.sink      cells,
    e2d_out_if.source   results,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [39:0] cfg_data
);
    import e2d_pkg::*;

    logic [15:0] grid_cols_reg;
    logic [8:0]  grid_rows_reg;
    logic [39:0] inv_two_dx_reg;
    logic [39:0] time_step_reg;
    logic        push;
    logic        pop;
    q_entry_t    push_entry;
    q_entry_t    head;
    q_stat_t     q_stat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_cols_reg  <= 16'd250;
            grid_rows_reg  <= 9'd50;
            inv_two_dx_reg <= 40'd838860800;
            time_step_reg  <= 40'd16777;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_GRID_COLS:  grid_cols_reg  <= cfg_data[15:0];
                CFG_GRID_ROWS:  grid_rows_reg  <= cfg_data[8:0];
                CFG_INV_TWO_DX: inv_two_dx_reg <= cfg_data;
                CFG_TIME_STEP:  time_step_reg  <= cfg_data;
                default:        grid_cols_reg  <= grid_cols_reg;
            endcase
        end
    end

    e2d_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cells      (cells),
        .grid_cols  (grid_cols_reg),
        .grid_rows  (grid_rows_reg),
        .push       (push),
        .push_entry (push_entry),
        .q_stat     (q_stat)
    );

    e2d_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .q_stat     (q_stat)
    );

    e2d_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_stat     (q_stat),
        .head       (head),
        .pop        (pop),
        .inv_two_dx (inv_two_dx_reg),
        .time_step  (time_step_reg),
        .results    (results)
    );

endmodule

@@ rtl/core/e2d_front.sv @@
// Front end: takes cells, tracks grid position, keeps two columns in a store,
// assembles the five-cell window and flags zero divisors. Uses e2d_pkg, e2d_if.
module e2d_front (
    input  logic               clk,
    input  logic               rst_n,
    e2d_in_if.sink             cells,
    input  logic [15:0]        grid_cols,
    input  logic [8:0]         grid_rows,
    output logic               push,
    output e2d_pkg::q_entry_t  push_entry,
    input  e2d_pkg::q_stat_t   q_stat
);
    import e2d_pkg::*;

    front_state_t               state_reg, state_next;
    logic [15:0]                col_reg, col_next;
    logic [8:0]                 row_reg, row_next;
    logic [CELL_W-1:0]          store [STORE_DEPTH];
    logic [CELL_W-1:0]          rd_a_reg, rd_b_reg;
    logic [STORE_AW-1:0]        rd_a_addr, rd_b_addr;
    logic [CELL_W-1:0]          cur_reg;
    logic [CELL_W-1:0]          cell_c_reg, cell_n_reg, cell_s_reg, cell_w_reg;
    logic [STORE_AW-1:0]        waddr_reg, caddr_reg, naddr_reg, saddr_reg;
    logic                       result_reg, last_reg;
    logic [15:0]                cols_eff;
    logic [8:0]                 rows_eff;
    logic                       accept;
    logic                       is_result;
    logic [9:0]                 row_inc;
    logic [16:0]                col_inc;
    logic [CELL_W-1:0]          win_cells [5];

    function automatic logic [STORE_AW-1:0] store_addr(input logic slot,
                                                       input logic [9:0] row);
        logic [STORE_AW-1:0] base;
        base = slot ? STORE_AW'(COL_SPAN) : '0;
        return base + STORE_AW'(row);
    endfunction

    assign cells.ready = (state_reg == F_IDLE);
    assign accept      = cells.valid && cells.ready;

    always_comb
    begin
        if (grid_rows == 9'd0)
            rows_eff = 9'd1;
        else if (grid_rows > 9'(MAX_ROWS))
            rows_eff = 9'(MAX_ROWS);
        else
            rows_eff = grid_rows;
        if (grid_cols == 16'd0)
            cols_eff = 16'd1;
        else if (grid_cols > 16'(MAX_COLS))
            cols_eff = 16'(MAX_COLS);
        else
            cols_eff = grid_cols;
    end

    assign is_result = (col_reg >= 16'd2) && ({1'b0, col_reg} <= {1'b0, cols_eff} + 17'd1)
                       && (row_reg >= 9'd1) && (row_reg <= rows_eff);
    assign row_inc   = {1'b0, row_reg} + 10'd1;
    assign col_inc   = {1'b0, col_reg} + 17'd1;

    always_comb
    begin
        state_next = state_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        push       = 1'b0;
        rd_a_addr  = naddr_reg;
        rd_b_addr  = saddr_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    state_next = F_READ_WC;
                    if (row_inc >= {1'b0, rows_eff} + 10'd2)
                    begin
                        row_next = 9'd0;
                        if (col_inc >= {1'b0, cols_eff} + 17'd2)
                            col_next = 16'd0;
                        else
                            col_next = col_inc[15:0];
                    end
                    else
                    begin
                        row_next = row_inc[8:0];
                    end
                end
            end
            F_READ_WC:
            begin
                rd_a_addr  = waddr_reg;
                rd_b_addr  = caddr_reg;
                state_next = F_READ_NS;
            end
            F_READ_NS:
            begin
                state_next = F_WRITE;
            end
            F_WRITE:
            begin
                state_next = result_reg ? F_PUSH : F_IDLE;
            end
            F_PUSH:
            begin
                if (!q_stat.full)
                begin
                    push       = 1'b1;
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            col_reg   <= '0;
            row_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == F_WRITE)
            store[waddr_reg] <= cur_reg;
        rd_a_reg <= store[rd_a_addr];
        rd_b_reg <= store[rd_b_addr];
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cur_reg    <= {cells.pressure_in, cells.scaled_momentum_y,
                           cells.scaled_momentum_x, cells.root_density};
            waddr_reg  <= store_addr(col_reg[0], {1'b0, row_reg});
            caddr_reg  <= store_addr(~col_reg[0], {1'b0, row_reg});
            naddr_reg  <= store_addr(~col_reg[0], {1'b0, row_reg} + 10'd1);
            saddr_reg  <= store_addr(~col_reg[0], {1'b0, row_reg} - 10'd1);
            result_reg <= is_result;
            last_reg   <= ({1'b0, col_reg} == {1'b0, cols_eff} + 17'd1)
                          && (row_reg == rows_eff);
        end
        if (state_reg == F_READ_NS)
        begin
            cell_w_reg <= rd_a_reg;
            cell_c_reg <= rd_b_reg;
        end
        if (state_reg == F_WRITE)
        begin
            cell_n_reg <= rd_a_reg;
            cell_s_reg <= rd_b_reg;
        end
    end

    always_comb
    begin
        win_cells[0] = cell_c_reg;
        win_cells[1] = cell_n_reg;
        win_cells[2] = cell_s_reg;
        win_cells[3] = cur_reg;
        win_cells[4] = cell_w_reg;
        push_entry.zero_div = 1'b0;
        push_entry.last     = last_reg;
        for (int i = 0; i < 5; i++)
        begin
            for (int f = 0; f < 4; f++)
                push_entry.window[4 * i + f] = win_cells[i][64 * f +: 64];
            if (win_cells[i][63:0] == 64'd0)
                push_entry.zero_div = 1'b1;
        end
    end

endmodule

@@ rtl/core/e2d_queue.sv @@
// Two-entry queue of classified windows between the front and back ends.
// Uses e2d_pkg.
module e2d_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  e2d_pkg::q_entry_t  push_entry,
    input  logic               pop,
    output e2d_pkg::q_entry_t  head,
    output e2d_pkg::q_stat_t   q_stat
);
    import e2d_pkg::*;

    q_entry_t   slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign head             = slot_reg[rd_ptr_reg];
    assign q_stat.full      = (count_reg == 2'd2);
    assign q_stat.not_empty = (count_reg != 2'd0);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = ~wr_ptr_reg;
        if (pop)
            rd_ptr_next = ~rd_ptr_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_entry;
    end

endmodule

@@ rtl/core/e2d_back.sv @@
// Back end: runs the residual and update program on a shared add unit,
// four-pass multiplier and bit-serial divider; holds the output item.
// Uses e2d_pkg, e2d_if.
module e2d_back (
    input  logic               clk,
    input  logic               rst_n,
    input  e2d_pkg::q_stat_t   q_stat,
    input  e2d_pkg::q_entry_t  head,
    output logic               pop,
    input  logic [39:0]        inv_two_dx,
    input  logic [39:0]        time_step,
    e2d_out_if.source          results
);
    import e2d_pkg::*;

    back_state_t   state_reg, state_next;
    logic [6:0]    pc_reg, pc_next;
    logic [4:0]    load_cnt_reg, load_cnt_next;
    fx_t           rf [RF_DEPTH];
    fx_t           opa_reg, opb_reg;
    logic          rf_we;
    rf_addr_t      rf_waddr;
    fx_t           rf_wdata;
    instr_t        instr;
    fx_res_t       res_reg, res_next;
    logic          sat_reg, sat_next;
    logic [63:0]   x_reg, x_next, y_reg, y_next;
    logic          neg_reg, neg_next;
    logic [127:0]  acc_reg, acc_next;
    logic [1:0]    step_reg, step_next;
    logic [63:0]   rem_reg, rem_next, lo_reg, lo_next, q_reg, q_next;
    logic [5:0]    cnt_reg, cnt_next;
    logic [63:0]   pp;
    logic [127:0]  pp_shifted;
    logic [63:0]   rem_sh;
    logic          take;
    fx_t [3:0]     res_hold_reg;
    logic          out_valid_reg, out_valid_next;
    fx_t [3:0]     out_val_reg;
    logic [1:0]    out_status_reg;
    logic          out_last_reg;
    logic          out_load;
    fx_t           load_val;

    assign instr = prog_instr(pc_reg);

    always_comb
    begin
        if (load_cnt_reg < 5'd20)
            load_val = head.window[load_cnt_reg];
        else
        begin
            case (rf_addr_t'(load_cnt_reg))
                RF_K:    load_val = {24'd0, inv_two_dx};
                RF_DT:   load_val = {24'd0, time_step};
                RF_G:    load_val = GAMMA_Q;
                default: load_val = GAMMA_M1_Q;
            endcase
        end
    end

    always_comb
    begin
        case (step_reg)
            2'd0:    pp = x_reg[31:0] * y_reg[31:0];
            2'd1:    pp = x_reg[31:0] * y_reg[63:32];
            2'd2:    pp = x_reg[63:32] * y_reg[31:0];
            default: pp = x_reg[63:32] * y_reg[63:32];
        endcase
        case (step_reg)
            2'd0:    pp_shifted = {64'd0, pp};
            2'd3:    pp_shifted = {pp, 64'd0};
            default: pp_shifted = {32'd0, pp, 32'd0};
        endcase
    end

    assign rem_sh = {rem_reg[62:0], lo_reg[63]};
    assign take   = rem_reg[63] || (rem_sh >= y_reg);

    always_comb
    begin
        state_next     = state_reg;
        pc_next        = pc_reg;
        load_cnt_next  = load_cnt_reg;
        res_next       = res_reg;
        sat_next       = sat_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        neg_next       = neg_reg;
        acc_next       = acc_reg;
        step_next      = step_reg;
        rem_next       = rem_reg;
        lo_next        = lo_reg;
        q_next         = q_reg;
        cnt_next       = cnt_reg;
        rf_we          = 1'b0;
        rf_waddr       = instr.dst;
        rf_wdata       = res_reg.value;
        pop            = 1'b0;
        out_load       = 1'b0;
        out_valid_next = out_valid_reg && !results.ready;
        unique case (state_reg)
            B_IDLE:
            begin
                if (q_stat.not_empty)
                begin
                    if (head.zero_div)
                        state_next = B_DONE;
                    else
                    begin
                        state_next    = B_LOAD;
                        load_cnt_next = '0;
                        sat_next      = 1'b0;
                    end
                end
            end
            B_LOAD:
            begin
                rf_we         = 1'b1;
                rf_waddr      = rf_addr_t'(load_cnt_reg);
                rf_wdata      = load_val;
                load_cnt_next = load_cnt_reg + 5'd1;
                if (load_cnt_reg == 5'(LOAD_LEN - 1))
                begin
                    pc_next    = '0;
                    state_next = B_FETCH;
                end
            end
            B_FETCH:
            begin
                state_next = B_EXEC;
            end
            B_EXEC:
            begin
                neg_next = opa_reg[63] ^ opb_reg[63];
                x_next   = fx_mag(opa_reg);
                y_next   = fx_mag(opb_reg);
                unique case (instr.op)
                    OP_ADD:
                    begin
                        res_next   = fx_add(opa_reg, opb_reg);
                        state_next = B_WB;
                    end
                    OP_SUB:
                    begin
                        res_next   = fx_sub(opa_reg, opb_reg);
                        state_next = B_WB;
                    end
                    OP_HALF:
                    begin
                        res_next   = fx_half(opa_reg);
                        state_next = B_WB;
                    end
                    OP_MUL:
                    begin
                        acc_next   = '0;
                        step_next  = '0;
                        state_next = B_MUL;
                    end
                    OP_DIV:
                    begin
                        if ({40'd0, x_next[63:40]} >= y_next)
                        begin
                            res_next   = fx_sat(1'b1, 64'd0, neg_next);
                            state_next = B_WB;
                        end
                        else
                        begin
                            rem_next   = {40'd0, x_next[63:40]};
                            lo_next    = {x_next[39:0], 24'd0};
                            q_next     = '0;
                            cnt_next   = '0;
                            state_next = B_DIV;
                        end
                    end
                    default:
                    begin
                        state_next = B_WB;
                    end
                endcase
            end
            B_MUL:
            begin
                acc_next  = acc_reg + pp_shifted;
                step_next = step_reg + 2'd1;
                if (step_reg == 2'd3)
                    state_next = B_MUL_FIN;
            end
            B_MUL_FIN:
            begin
                res_next   = fx_sat(|acc_reg[127:88], acc_reg[87:24], neg_reg);
                state_next = B_WB;
            end
            B_DIV:
            begin
                rem_next = take ? (rem_sh - y_reg) : rem_sh;
                lo_next  = {lo_reg[62:0], 1'b0};
                q_next   = {q_reg[62:0], take};
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd63)
                    state_next = B_DIV_FIN;
            end
            B_DIV_FIN:
            begin
                res_next   = fx_sat(1'b0, q_reg, neg_reg);
                state_next = B_WB;
            end
            B_WB:
            begin
                rf_we    = 1'b1;
                sat_next = sat_reg | res_reg.sat;
                pc_next  = pc_reg + 7'd1;
                if (pc_reg == 7'(PROG_LEN - 1))
                    state_next = B_DONE;
                else
                    state_next = B_FETCH;
            end
            B_DONE:
            begin
                if (!out_valid_reg || results.ready)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    pop            = 1'b1;
                    state_next     = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            pc_reg        <= '0;
            load_cnt_reg  <= '0;
            step_reg      <= '0;
            cnt_reg       <= '0;
            sat_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pc_reg        <= pc_next;
            load_cnt_reg  <= load_cnt_next;
            step_reg      <= step_next;
            cnt_reg       <= cnt_next;
            sat_reg       <= sat_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
        neg_reg <= neg_next;
        acc_reg <= acc_next;
        rem_reg <= rem_next;
        lo_reg  <= lo_next;
        q_reg   <= q_next;
        if (rf_we)
            rf[rf_waddr] <= rf_wdata;
        opa_reg <= rf[instr.src_a];
        opb_reg <= rf[instr.src_b];
        if ((state_reg == B_WB) && (instr.dst >= RF_RES0))
            res_hold_reg[2'(instr.dst - RF_RES0)] <= res_reg.value;
        if (out_load)
        begin
            out_last_reg <= head.last;
            if (head.zero_div)
            begin
                out_val_reg    <= head.window[3:0];
                out_status_reg <= ST_ZERO_DIV;
            end
            else
            begin
                out_val_reg    <= res_hold_reg;
                out_status_reg <= sat_reg ? ST_SAT : ST_OK;
            end
        end
    end

    assign results.valid            = out_valid_reg;
    assign results.new_root_density = out_val_reg[0];
    assign results.new_momentum_x   = out_val_reg[1];
    assign results.new_momentum_y   = out_val_reg[2];
    assign results.new_pressure     = out_val_reg[3];
    assign results.status           = out_status_reg;
    assign results.last_of_frame    = out_last_reg;

endmodule
